// ===== src/dfg_pkg.sv =====
`default_nettype none

package dfg_pkg;

	localparam int VAL_W  = 32;
	localparam int SEP_W  = 8;
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 4;
	localparam int DIGITS = 10;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int BIT_W  = 5;
	localparam int POS_W  = 4;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

	// digit positions counted from the billions digit
	localparam logic [POS_W-1:0] POS_GROUP_A = 4'd1;
	localparam logic [POS_W-1:0] POS_GROUP_B = 4'd4;
	localparam logic [POS_W-1:0] POS_GROUP_C = 4'd7;
	localparam logic [POS_W-1:0] POS_LAST    = 4'd9;

	localparam logic [BIT_W-1:0] BIT_LAST = 5'd31;

	typedef logic [1:0] step_t;

	localparam step_t STEP_WAIT = 2'd0;
	localparam step_t STEP_CONV = 2'd1;
	localparam step_t STEP_SEP  = 2'd2;
	localparam step_t STEP_DIG  = 2'd3;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_CONV,
		OP_SEP,
		OP_DIG
	} op_t;

	typedef enum logic [1:0] {
		JC_START,
		JC_CONV_DONE,
		JC_NOT_LAST,
		JC_ALWAYS
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ctrl_t;

	typedef struct packed {
		logic conv_done;
		logic last_pos;
	} status_t;

endpackage

`default_nettype wire

// ===== src/dfg_ucode_rom.sv =====
`default_nettype none

module dfg_ucode_rom (
	input  wire dfg_pkg::step_t step,
	output dfg_pkg::ctrl_t      ctrl
);

	always_comb begin
		case (step)
			dfg_pkg::STEP_WAIT: begin
				ctrl = '{dfg_pkg::OP_IDLE, dfg_pkg::JC_START,
					dfg_pkg::STEP_CONV, dfg_pkg::STEP_WAIT};
			end
			dfg_pkg::STEP_CONV: begin
				ctrl = '{dfg_pkg::OP_CONV, dfg_pkg::JC_CONV_DONE,
					dfg_pkg::STEP_SEP, dfg_pkg::STEP_CONV};
			end
			dfg_pkg::STEP_SEP: begin
				ctrl = '{dfg_pkg::OP_SEP, dfg_pkg::JC_ALWAYS,
					dfg_pkg::STEP_DIG, dfg_pkg::STEP_DIG};
			end
			dfg_pkg::STEP_DIG: begin
				ctrl = '{dfg_pkg::OP_DIG, dfg_pkg::JC_NOT_LAST,
					dfg_pkg::STEP_SEP, dfg_pkg::STEP_WAIT};
			end
			default: begin
				ctrl = '{dfg_pkg::OP_IDLE, dfg_pkg::JC_ALWAYS,
					dfg_pkg::STEP_WAIT, dfg_pkg::STEP_WAIT};
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/dfg_datapath.sv =====
`default_nettype none

module dfg_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire dfg_pkg::ctrl_t              ctrl,
	input  wire                              load,
	input  wire [dfg_pkg::VAL_W-1:0]         value,
	input  wire [dfg_pkg::SEP_W-1:0]         separator,
	output dfg_pkg::status_t                 status,
	output logic                             strobe,
	output logic [dfg_pkg::CHAR_W-1:0]       char_out,
	output logic                             is_last,
	output logic [dfg_pkg::LEN_W-1:0]        total_length
);

	logic [dfg_pkg::VAL_W-1:0]  bin_q;
	logic [dfg_pkg::BCD_W-1:0]  bcd_q;
	logic [dfg_pkg::SEP_W-1:0]  sep_q;
	logic [dfg_pkg::BIT_W-1:0]  bit_q;
	logic [dfg_pkg::POS_W-1:0]  pos_q;
	logic [dfg_pkg::LEN_W-1:0]  len_q;
	logic                       emit_q;
	logic                       strobe_q;
	logic [dfg_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;
	logic [dfg_pkg::LEN_W-1:0]  tlen_q;

	logic [dfg_pkg::BCD_W-1:0]  bcd_adj;
	logic [3:0]                 dig;
	logic                       at_group;
	logic                       at_last;
	logic                       sep_go;
	logic                       dig_go;

	// add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < dfg_pkg::DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	assign dig      = bcd_q[dfg_pkg::BCD_W-1 -: 4];
	assign at_group = (pos_q == dfg_pkg::POS_GROUP_A) || (pos_q == dfg_pkg::POS_GROUP_B) ||
		(pos_q == dfg_pkg::POS_GROUP_C);
	assign at_last  = (pos_q == dfg_pkg::POS_LAST);
	assign sep_go   = (ctrl.op == dfg_pkg::OP_SEP) && emit_q && (sep_q != '0) && at_group;
	assign dig_go   = (ctrl.op == dfg_pkg::OP_DIG) && ((dig != 4'd0) || emit_q || at_last);

	assign status.conv_done = (bit_q == dfg_pkg::BIT_LAST);
	assign status.last_pos  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q    <= '0;
			bcd_q    <= '0;
			sep_q    <= '0;
			bit_q    <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			emit_q   <= 1'b0;
			strobe_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
			tlen_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (load) begin
				bin_q  <= value;
				bcd_q  <= '0;
				sep_q  <= separator;
				bit_q  <= '0;
				pos_q  <= '0;
				len_q  <= '0;
				emit_q <= 1'b0;
			end
			if (ctrl.op == dfg_pkg::OP_CONV) begin
				bcd_q <= {bcd_adj[dfg_pkg::BCD_W-2:0], bin_q[dfg_pkg::VAL_W-1]};
				bin_q <= {bin_q[dfg_pkg::VAL_W-2:0], 1'b0};
				bit_q <= bit_q + 1'b1;
			end
			if (sep_go) begin
				strobe_q <= 1'b1;
				char_q   <= sep_q;
				last_q   <= 1'b0;
				tlen_q   <= '0;
				len_q    <= len_q + 1'b1;
			end
			if (ctrl.op == dfg_pkg::OP_DIG) begin
				bcd_q <= {bcd_q[dfg_pkg::BCD_W-5:0], 4'd0};
				pos_q <= pos_q + 1'b1;
			end
			if (dig_go) begin
				strobe_q <= 1'b1;
				char_q   <= dfg_pkg::ASCII_ZERO + {4'd0, dig};
				last_q   <= at_last;
				tlen_q   <= at_last ? len_q + 1'b1 : '0;
				len_q    <= len_q + 1'b1;
				emit_q   <= 1'b1;
			end
		end
	end

	assign strobe       = strobe_q;
	assign char_out     = char_q;
	assign is_last      = last_q;
	assign total_length = tlen_q;

endmodule

`default_nettype wire

// ===== src/decimal_formatter_grouped.sv =====
// Output: the first character beat follows the conversion loop; leading zero digits
//   emit nothing, then each character takes one beat, and the loop alternates a separator
//   step and a digit step, so an idle step sits wherever no separator goes in.
// Numbers: start is taken only in the wait step, so a new number loads once the
//   bit-serial binary-to-BCD loop and the two-step digit loop are through.
// Reset: arst_n clears the step counter and the strobe at once; receiver cannot stall.
`default_nettype none

module decimal_formatter_grouped (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire [dfg_pkg::VAL_W-1:0]    value,
	input  wire [dfg_pkg::SEP_W-1:0]    separator,
	output logic                        strobe,
	output logic [dfg_pkg::CHAR_W-1:0]  char_out,
	output logic                        is_last,
	output logic [dfg_pkg::LEN_W-1:0]   total_length
);

	// Sequencer: a step counter walks a four-word control store.
	//   WAIT: hold until start, load the number.
	//   CONV: shift-and-add-three, one binary bit per cycle, 32 passes.
	//   SEP : drop a separator beat ahead of a group if digits came before and the separator is nonzero.
	//   DIG : emit the top BCD digit unless it is a leading zero, advance.
	dfg_pkg::step_t   step_q;
	dfg_pkg::step_t   step_nxt;
	dfg_pkg::ctrl_t   ctrl;
	dfg_pkg::status_t status;
	logic             take;
	logic             load;

	dfg_ucode_rom u_rom (
		.step (step_q),
		.ctrl (ctrl)
	);

	// Evaluate the jump condition of the current control word.
	always_comb begin
		case (ctrl.cond)
			dfg_pkg::JC_START:     take = start;
			dfg_pkg::JC_CONV_DONE: take = status.conv_done;
			dfg_pkg::JC_NOT_LAST:  take = !status.last_pos;
			dfg_pkg::JC_ALWAYS:    take = 1'b1;
			default:               take = 1'b1;
		endcase
		step_nxt = take ? ctrl.jmp : ctrl.nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dfg_pkg::STEP_WAIT;
		end else begin
			step_q <= step_nxt;
		end
	end

	// Busy whenever the program is past its wait step; the last result beat
	// sits in the output register while the next number may already load.
	assign busy = (step_q != dfg_pkg::STEP_WAIT);
	assign load = start && !busy;

	dfg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.load         (load),
		.value        (value),
		.separator    (separator),
		.status       (status),
		.strobe       (strobe),
		.char_out     (char_out),
		.is_last      (is_last),
		.total_length (total_length)
	);

endmodule

`default_nettype wire
